>>> src/fsi_pkg.sv
// shared types, codes and helpers for the ip flow statistics table
`timescale 1ns / 1ps
package fsi_pkg;

  localparam int unsigned FLOW_SLOTS_DEF = 256;

  localparam logic [1:0] STATUS_NOT_IPV4 = 2'd0;
  localparam logic [1:0] STATUS_NEW      = 2'd1;
  localparam logic [1:0] STATUS_HIT      = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [3:0] VERSION_IPV4 = 4'd4;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_FTP   = 16'd21;
  localparam logic [15:0] PORT_DNS   = 16'd53;

  localparam logic [2:0] APP_NONE    = 3'd0;
  localparam logic [2:0] APP_UNKNOWN = 3'd1;
  localparam logic [2:0] APP_HTTP    = 3'd2;
  localparam logic [2:0] APP_HTTPS   = 3'd3;
  localparam logic [2:0] APP_FTP     = 3'd4;
  localparam logic [2:0] APP_DNS     = 3'd5;

  // per-flow counter record
  typedef struct packed {
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] tcp;
    logic [31:0] udp;
    logic [2:0]  app;
  } flow_rec_t;

  function automatic logic [2:0] app_from_port(input logic [15:0] port);
    logic [2:0] code;
    unique case (port)
      PORT_HTTP:  code = APP_HTTP;
      PORT_HTTPS: code = APP_HTTPS;
      PORT_FTP:   code = APP_FTP;
      PORT_DNS:   code = APP_DNS;
      default:    code = APP_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

>>> src/fsi_key_mem.sv
// flow key memory, one write and one registered read port
`timescale 1ns / 1ps
module fsi_key_mem #(
  parameter int unsigned FLOW_SLOTS = fsi_pkg::FLOW_SLOTS_DEF,
  localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  logic [63:0]       wr_data_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output logic [63:0]       rd_data_o
);

  logic [63:0] mem_q [FLOW_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> src/fsi_cnt_mem.sv
// per-flow counter memory, one write and one registered read port
`timescale 1ns / 1ps
module fsi_cnt_mem #(
  parameter int unsigned FLOW_SLOTS = fsi_pkg::FLOW_SLOTS_DEF,
  localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [SLOT_W-1:0]  wr_addr_i,
  input  fsi_pkg::flow_rec_t wr_data_i,
  input  logic [SLOT_W-1:0]  rd_addr_i,
  output fsi_pkg::flow_rec_t rd_data_o
);

  fsi_pkg::flow_rec_t mem_q [FLOW_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> src/ip_flow_statistics_table_top.sv
// top level of the ip flow statistics table: control, global counters, output register
`timescale 1ns / 1ps
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------------
// in      | input     | in_valid_i/in_ready_o | version_ihl, ip_protocol, addresses,
//         |           |                      | dest_port, frame_length
// out     | output    | out_valid_o/out_ready_i | status, flow_*, total_*
//
// one packet at a time: accept, then a linear key scan over the stored flows
// (key memory read, then compare), then for a hit a counter read and a write back;
// a new flow skips the counter read; full or non-ipv4 packets write nothing
// the scan over the key memory sets the time per packet, which grows with the fill
// reset clears the fill count and global counters; the memories need no clearing
// the output register holds a result while out_ready_i is low; the next packet
// is still taken and waits at the end of its work until the register frees
module ip_flow_statistics_table_top #(
  parameter int unsigned FLOW_SLOTS = fsi_pkg::FLOW_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  version_ihl_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] frame_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  flow_slot_o,
  output logic [31:0] flow_packets_o,
  output logic [31:0] flow_bytes_o,
  output logic [31:0] flow_tcp_packets_o,
  output logic [31:0] flow_udp_packets_o,
  output logic [2:0]  flow_app_code_o,
  output logic [31:0] total_packets_o,
  output logic [31:0] total_bytes_o,
  output logic [31:0] total_tcp_packets_o,
  output logic [31:0] total_udp_packets_o
);

  localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int unsigned FILL_W = $clog2(FLOW_SLOTS + 1);
  localparam logic [FILL_W-1:0] SLOTS_F = FILL_W'(FLOW_SLOTS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,  // key read issued
    ST_CMP  = 6'b000100,  // key compare
    ST_CRD  = 6'b001000,  // counter read issued
    ST_UPD  = 6'b010000,  // counter update and write back
    ST_OUT  = 6'b100000   // result waits for the output register
  } state_e;

  state_e state_q, state_d;

  // latched packet
  logic [7:0]  proto_q;
  logic [63:0] key_q;
  logic [15:0] port_q;
  logic [15:0] len_q;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              new_q, new_d;

  logic [31:0] g_pkt_q, g_byte_q, g_tcp_q, g_udp_q;

  // staged result
  logic [1:0]          res_status_q, res_status_d;
  fsi_pkg::flow_rec_t  res_rec_q, res_rec_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;

  logic               out_valid_q;
  logic               out_load;

  logic               key_wr_en;
  logic [63:0]        key_rd_data;
  logic               cnt_wr_en;
  fsi_pkg::flow_rec_t cnt_rd_data;
  fsi_pkg::flow_rec_t upd_rec;

  logic in_xfer;
  logic is_ipv4;
  logic is_tcp, is_udp;
  logic last_entry;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_ipv4    = (version_ihl_i[7:4] == fsi_pkg::VERSION_IPV4);
  assign is_tcp     = (proto_q == fsi_pkg::PROTO_TCP);
  assign is_udp     = (proto_q == fsi_pkg::PROTO_UDP);
  assign last_entry = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // a new flow writes its key together with the counter write back
  assign key_wr_en = (state_q == ST_UPD) && new_q;

  fsi_key_mem #(.FLOW_SLOTS(FLOW_SLOTS)) u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (res_slot_q),
    .wr_data_i (key_q),
    .rd_addr_i (idx_q),
    .rd_data_o (key_rd_data)
  );

  // new flow starts from zero counters
  always_comb begin
    fsi_pkg::flow_rec_t base;
    base = new_q ? '0 : cnt_rd_data;
    upd_rec         = base;
    upd_rec.packets = base.packets + 32'd1;
    upd_rec.bytes   = base.bytes + 32'(len_q);
    if (is_tcp) begin
      upd_rec.tcp = base.tcp + 32'd1;
      upd_rec.app = fsi_pkg::app_from_port(port_q);
    end else if (is_udp) begin
      upd_rec.udp = base.udp + 32'd1;
    end
  end

  assign cnt_wr_en = (state_q == ST_UPD);

  fsi_cnt_mem #(.FLOW_SLOTS(FLOW_SLOTS)) u_cnt_mem (
    .clk_i     (clk_i),
    .wr_en_i   (cnt_wr_en),
    .wr_addr_i (res_slot_q),
    .wr_data_i (upd_rec),
    .rd_addr_i (res_slot_q),
    .rd_data_o (cnt_rd_data)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    new_d        = new_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    res_slot_d   = res_slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_d     = '0;
          new_d     = 1'b0;
          res_rec_d = '0;
          res_slot_d = '0;
          if (!is_ipv4) begin
            res_status_d = fsi_pkg::STATUS_NOT_IPV4;
            state_d      = ST_OUT;
          end else if (fill_q == '0) begin
            // empty table goes straight to insert
            res_status_d = fsi_pkg::STATUS_NEW;
            new_d        = 1'b1;
            fill_d       = fill_q + FILL_W'(1);
            state_d      = ST_UPD;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (key_rd_data == key_q) begin
          res_status_d = fsi_pkg::STATUS_HIT;
          res_slot_d   = idx_q;
          state_d      = ST_CRD;
        end else if (!last_entry) begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = ST_READ;
        end else if (fill_q != SLOTS_F) begin
          res_status_d = fsi_pkg::STATUS_NEW;
          res_slot_d   = fill_q[SLOT_W-1:0];
          new_d        = 1'b1;
          fill_d       = fill_q + FILL_W'(1);
          state_d      = ST_UPD;
        end else begin
          res_status_d = fsi_pkg::STATUS_FULL;
          state_d      = ST_OUT;
        end
      end
      ST_CRD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        res_rec_d = upd_rec;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      g_pkt_q     <= '0;
      g_byte_q    <= '0;
      g_tcp_q     <= '0;
      g_udp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      // global counters move at accept time
      if (in_xfer && is_ipv4) begin
        g_pkt_q  <= g_pkt_q + 32'd1;
        g_byte_q <= g_byte_q + 32'(frame_length_i);
        if (ip_protocol_i == fsi_pkg::PROTO_TCP) begin
          g_tcp_q <= g_tcp_q + 32'd1;
        end else if (ip_protocol_i == fsi_pkg::PROTO_UDP) begin
          g_udp_q <= g_udp_q + 32'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    new_q        <= new_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    res_slot_q   <= res_slot_d;
    if (in_xfer) begin
      proto_q <= ip_protocol_i;
      key_q   <= {source_address_i, dest_address_i};
      port_q  <= dest_port_i;
      len_q   <= frame_length_i;
    end
    if (out_load) begin
      status_o            <= res_status_q;
      flow_slot_o         <= 8'(17'(res_slot_q));
      flow_packets_o      <= res_rec_q.packets;
      flow_bytes_o        <= res_rec_q.bytes;
      flow_tcp_packets_o  <= res_rec_q.tcp;
      flow_udp_packets_o  <= res_rec_q.udp;
      flow_app_code_o     <= res_rec_q.app;
      total_packets_o     <= g_pkt_q;
      total_bytes_o       <= g_byte_q;
      total_tcp_packets_o <= g_tcp_q;
      total_udp_packets_o <= g_udp_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SLOTS_F)
    else $error("fill count beyond table size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second packet taken while one is in work");

  a_new_flow_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fsi_pkg::STATUS_NEW |-> flow_packets_o == 32'd1)
    else $error("new flow result without a packet count of one");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fsi_pkg::STATUS_FULL |-> fill_q == SLOTS_F)
    else $error("table full reported with free slots");
`endif

endmodule

>>> sim/tb.sv
// testbench for the ip flow statistics table: directed and random packets, scoreboard check
`timescale 1ns / 1ps
module tb;

  localparam int unsigned SLOTS = fsi_pkg::FLOW_SLOTS_DEF;

  // one expected result
  typedef struct {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] pkts;
    logic [31:0] bytes;
    logic [31:0] tcp;
    logic [31:0] udp;
    logic [2:0]  app;
    logic [31:0] tot_pkts;
    logic [31:0] tot_bytes;
    logic [31:0] tot_tcp;
    logic [31:0] tot_udp;
  } flow_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0]  version_ihl_i = '0;
  logic [7:0]  ip_protocol_i = '0;
  logic [31:0] source_address_i = '0;
  logic [31:0] dest_address_i = '0;
  logic [15:0] dest_port_i = '0;
  logic [15:0] frame_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  flow_slot_o;
  logic [31:0] flow_packets_o, flow_bytes_o, flow_tcp_packets_o, flow_udp_packets_o;
  logic [2:0]  flow_app_code_o;
  logic [31:0] total_packets_o, total_bytes_o, total_tcp_packets_o, total_udp_packets_o;

  ip_flow_statistics_table_top uut (.*);

  // predictor state
  logic [63:0] key_tab[SLOTS];
  logic [31:0] pkt_tab[SLOTS], byte_tab[SLOTS], tcp_tab[SLOTS], udp_tab[SLOTS];
  logic [2:0]  app_tab[SLOTS];
  int unsigned fill;
  logic [31:0] g_pkts, g_bytes, g_tcp, g_udp;

  flow_result_t pending_results[$];
  int errors;
  bit idle_enable;   // random idling on both sides

  // address pool so flows repeat
  logic [31:0] addr_pool[16];

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("ip_flow_statistics_table_top test failed");
    $finish;
  end

  function automatic logic [2:0] port_to_app(logic [15:0] port);
    case (port)
      fsi_pkg::PORT_HTTP:  return fsi_pkg::APP_HTTP;
      fsi_pkg::PORT_HTTPS: return fsi_pkg::APP_HTTPS;
      fsi_pkg::PORT_FTP:   return fsi_pkg::APP_FTP;
      fsi_pkg::PORT_DNS:   return fsi_pkg::APP_DNS;
      default:             return fsi_pkg::APP_UNKNOWN;
    endcase
  endfunction

  // compute the result of one packet and advance the predictor state
  function automatic flow_result_t account_packet(logic [7:0] vi, logic [7:0] proto,
      logic [31:0] src, logic [31:0] dst, logic [15:0] port, logic [15:0] len);
    flow_result_t r;
    logic [63:0] key;
    int slot;
    bit is_tcp, is_udp;
    key = {src, dst};
    is_tcp = (proto == fsi_pkg::PROTO_TCP);
    is_udp = (proto == fsi_pkg::PROTO_UDP);
    r = '{default: '0};
    r.status = fsi_pkg::STATUS_NOT_IPV4;
    slot = -1;
    if (vi[7:4] == fsi_pkg::VERSION_IPV4) begin
      g_pkts += 1;
      g_bytes += len;
      if (is_tcp) g_tcp += 1;
      else if (is_udp) g_udp += 1;
      for (int i = 0; i < fill; i++) begin
        if (slot < 0 && key_tab[i] == key) slot = i;
      end
      if (slot >= 0) begin
        r.status = fsi_pkg::STATUS_HIT;
      end else if (fill < SLOTS) begin
        slot = fill;
        key_tab[slot] = key;
        pkt_tab[slot] = '0;
        byte_tab[slot] = '0;
        tcp_tab[slot] = '0;
        udp_tab[slot] = '0;
        app_tab[slot] = fsi_pkg::APP_NONE;
        fill++;
        r.status = fsi_pkg::STATUS_NEW;
      end else begin
        r.status = fsi_pkg::STATUS_FULL;
      end
      if (slot >= 0) begin
        pkt_tab[slot] += 1;
        byte_tab[slot] += len;
        if (is_tcp) begin
          tcp_tab[slot] += 1;
          app_tab[slot] = port_to_app(port);
        end else if (is_udp) begin
          udp_tab[slot] += 1;
        end
        r.slot = slot[7:0];
        r.pkts = pkt_tab[slot];
        r.bytes = byte_tab[slot];
        r.tcp = tcp_tab[slot];
        r.udp = udp_tab[slot];
        r.app = app_tab[slot];
      end
    end
    r.tot_pkts = g_pkts;
    r.tot_bytes = g_bytes;
    r.tot_tcp = g_tcp;
    r.tot_udp = g_udp;
    return r;
  endfunction

  // one transfer on the input channel, with an optional random gap first
  // valid stays high after the transfer until the next packet or a gap replaces it
  task automatic send_packet(logic [7:0] vi, logic [7:0] proto, logic [31:0] src,
      logic [31:0] dst, logic [15:0] port, logic [15:0] len);
    while (idle_enable && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    version_ihl_i <= vi;
    ip_protocol_i <= proto;
    source_address_i <= src;
    dest_address_i <= dst;
    dest_port_i <= port;
    frame_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(account_packet(vi, proto, src, dst, port, len));
  endtask

  // receiver: random backpressure and field compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result status=%0d", status_o);
        end else begin
          flow_result_t e;
          e = pending_results.pop_front();
          if (status_o !== e.status || flow_slot_o !== e.slot ||
              flow_packets_o !== e.pkts || flow_bytes_o !== e.bytes ||
              flow_tcp_packets_o !== e.tcp || flow_udp_packets_o !== e.udp ||
              flow_app_code_o !== e.app || total_packets_o !== e.tot_pkts ||
              total_bytes_o !== e.tot_bytes || total_tcp_packets_o !== e.tot_tcp ||
              total_udp_packets_o !== e.tot_udp) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp st=%0d sl=%0d p=%h b=%h t=%h u=%h a=%0d T=%h %h %h %h",
                       e.status, e.slot, e.pkts, e.bytes, e.tcp, e.udp, e.app,
                       e.tot_pkts, e.tot_bytes, e.tot_tcp, e.tot_udp);
              $display("         got st=%0d sl=%0d p=%h b=%h t=%h u=%h a=%0d T=%h %h %h %h",
                       status_o, flow_slot_o, flow_packets_o, flow_bytes_o,
                       flow_tcp_packets_o, flow_udp_packets_o, flow_app_code_o,
                       total_packets_o, total_bytes_o, total_tcp_packets_o,
                       total_udp_packets_o);
            end
          end
        end
      end
      out_ready_i <= !(idle_enable && $urandom_range(99) < 27);
    end
  end

  // drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_proto();
    case ($urandom_range(3))
      0: return fsi_pkg::PROTO_TCP;
      1: return fsi_pkg::PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_port();
    case ($urandom_range(5))
      0: return fsi_pkg::PORT_HTTP;
      1: return fsi_pkg::PORT_HTTPS;
      2: return fsi_pkg::PORT_FTP;
      3: return fsi_pkg::PORT_DNS;
      default: return 16'($urandom);
    endcase
  endfunction

  // extremes, every protocol and app code, non-ipv4 and repeat flows
  task automatic test_directed();
    send_packet(8'h45, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'h0);
    send_packet(8'h45, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_HTTPS, 16'hffff);
    send_packet(8'h4f, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_FTP, 16'h8000);
    send_packet(8'h40, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_DNS, 16'h1);
    send_packet(8'h45, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, 16'hffff, 16'h40);
    send_packet(8'h45, fsi_pkg::PROTO_UDP, 32'h0, 32'h0, fsi_pkg::PORT_DNS, 16'h40);
    send_packet(8'h45, 8'hff, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'h40);
    send_packet(8'h45, 8'h00, 32'hffffffff, 32'hffffffff, 16'h0, 16'hffff);
    send_packet(8'h45, fsi_pkg::PROTO_UDP, 32'hffffffff, 32'hffffffff, 16'h0, 16'hffff);
    send_packet(8'h45, fsi_pkg::PROTO_TCP, 32'hffffffff, 32'h0, fsi_pkg::PORT_HTTP,
                16'h5dc);
    send_packet(8'h45, fsi_pkg::PROTO_TCP, 32'h0, 32'hffffffff, fsi_pkg::PORT_HTTP,
                16'h5dc);
    // non-ipv4 versions leave state untouched
    send_packet(8'h60, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'hffff);
    send_packet(8'hff, fsi_pkg::PROTO_UDP, 32'hffffffff, 32'h0, 16'hffff, 16'hffff);
    send_packet(8'h00, 8'h00, 32'h12345678, 32'h9abcdef0, 16'h0, 16'h0);
    send_packet(8'h35, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'h10);
    send_packet(8'h5f, fsi_pkg::PROTO_TCP, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'h10);
    // non-tcp on a flow keeps its app code
    send_packet(8'h45, fsi_pkg::PROTO_UDP, 32'h0, 32'h0, fsi_pkg::PORT_HTTP, 16'h20);
    wait_drained();
  endtask

  // mostly repeat flows from a small pool, plus noise
  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      logic [31:0] src, dst;
      if ($urandom_range(9) < 8) begin
        src = addr_pool[$urandom_range(15)];
        dst = addr_pool[$urandom_range(15)];
      end else begin
        src = $urandom;
        dst = $urandom;
      end
      send_packet(($urandom_range(9) < 8) ? {fsi_pkg::VERSION_IPV4, 4'($urandom)} :
                  8'($urandom), random_proto(), src, dst, random_port(), 16'($urandom));
      // sender holds off until the table has caught up
      if (n == count / 2) wait_drained();
    end
  endtask

  // fill every slot with fresh flows, then hit the full table
  task automatic test_table_full();
    for (int n = fill; n < SLOTS; n++)
      send_packet(8'h45, random_proto(), 32'hc0a80000 + n, 32'h0a000000 + n,
                  random_port(), 16'($urandom));
    for (int n = 0; n < 60; n++)
      send_packet(8'h45, random_proto(), $urandom, $urandom, random_port(), 16'($urandom));
    for (int n = 0; n < 60; n++)
      send_packet(8'h45, random_proto(), addr_pool[$urandom_range(15)],
                  addr_pool[$urandom_range(15)], random_port(), 16'($urandom));
    wait_drained();
  endtask

  initial begin
    fill = 0;
    g_pkts = '0;
    g_bytes = '0;
    g_tcp = '0;
    g_udp = '0;
    errors = 0;
    idle_enable = 1'b1;
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hffffffff;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(100);
    // long stretch with no idling on either side
    idle_enable = 1'b0;
    test_random_traffic(60);
    idle_enable = 1'b1;
    test_table_full();
    repeat (600) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ip_flow_statistics_table_top test passed");
    end else begin
      $display("ip_flow_statistics_table_top test failed");
    end
    $finish;
  end
endmodule
